// ===== rtl/assert_macros.svh =====
// Assertion macros used by the port-level checker.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, off while reset is high
`define BFSA_ASSERT_IMP(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, off while reset is high
`define BFSA_ASSERT_NXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/bfsa_pkg.sv =====
// Shared types, codes and sizes for the best-fit segment allocator.
// Depends on nothing; imported by the top level and its checker.
`timescale 1ns / 1ps

package bfsa_pkg;

   localparam int MaxSegments = 256;
   localparam int SegAw       = $clog2(MaxSegments);
   localparam int CntW        = SegAw + 1;
   localparam int DataW       = 31;
   localparam int HandleW     = 8;
   localparam int PartW       = 3;
   localparam logic [DataW-1:0] DiskReset = DataW'(1048576);
   localparam logic [DataW-1:0] DiskMin   = DataW'(8);

   typedef enum logic [1:0] {
      MODE_ALLOC   = 2'd0,
      MODE_FREE    = 2'd1,
      MODE_COMPACT = 2'd2,
      MODE_REPORT  = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STAT_PLACED  = 2'd0,
      STAT_FULL    = 2'd1,
      STAT_IGNORED = 2'd2,
      STAT_DONE    = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      LVL_FULL    = 2'd0,
      LVL_PARTIAL = 2'd1,
      LVL_EMPTY   = 2'd2
   } level_type;

   typedef struct packed {
      logic [1:0]         mode;
      logic [HandleW-1:0] handle;
      logic [DataW-1:0]   length;
   } req_type;

   typedef struct packed {
      logic [1:0]       status;
      logic [DataW-1:0] address;
      logic [1:0]       level;
      logic             last;
   } rsp_type;

   typedef struct packed {
      logic [DataW-1:0]   start;
      logic [DataW-1:0]   size;
      logic               used;
      logic [HandleW-1:0] owner;
   } entry_type;

   typedef enum logic [4:0] {
      S_INIT, S_IDLE,
      S_FIT_RD, S_FIT_EX, S_FIT_END, S_SH_RD, S_SH_EX, S_SPL_WR, S_ALC_WR,
      S_FREE_RD, S_FREE_EX, S_NX_RD, S_NX_EX, S_PV_RD, S_PV_EX,
      S_RM_RD, S_RM_EX,
      S_CMP_RD, S_CMP_EX, S_CMP_TAIL,
      S_REP_RD, S_REP_EX, S_REP_OUT,
      S_RESP
   } fsm_type;

endpackage

// ===== rtl/best_fit_segment_allocator.sv =====
// Best-fit segment allocator: segment table in one synchronous RAM plus sequencer.
// Depends on bfsa_pkg.
`timescale 1ns / 1ps
//
// Usage
//   req channel (req_valid/req_ready/req_data) carries one command: allocate,
//   free, compact or report. rsp channel (rsp_valid/rsp_ready/rsp_data) returns
//   one result per command, eight for a report, the final one flagged by last.
//   csr_write_en/csr_write_data set the disk size and clear the table.
//   The sequencer walks the table of n segments, each entry a RAM read then
//   an update. Allocate runs a best-fit search, then shifts upper entries for
//   a split, or compacts and retries once; free searches, then closes up to
//   two gaps; compact walks once; report walks once per eighth. req_ready is
//   high only between commands.
//   The result sits in an output register: a command may be accepted while
//   the previous result still waits; a stalled receiver holds the sequencer
//   only when a new result must be loaded.
//   Reset (synchronous) and every size write rebuild the table as a single
//   free segment in S_INIT; req_ready stays low while it does.
//
module best_fit_segment_allocator
   import bfsa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_ready,
   input  req_type          req_data,
   output logic             rsp_valid,
   input  logic             rsp_ready,
   output rsp_type          rsp_data,
   input  logic             csr_write_en,
   input  logic [DataW-1:0] csr_write_data
);

   // Segment table RAM
   entry_type mem [MaxSegments];
   entry_type mem_rdata_ff;
   logic             mem_we;
   logic [SegAw-1:0] mem_waddr, mem_raddr;
   entry_type        mem_wdata;

   fsm_type state_ff, state_in;
   logic [DataW-1:0] disk_ff, disk_in;
   logic [DataW-1:0] free_ff, free_in;
   logic [CntW-1:0]  count_ff, count_in;
   logic [CntW-1:0]  idx_ff, idx_in;
   logic [CntW-1:0]  pos_ff, pos_in;
   entry_type        cur_ff, cur_in;
   logic             found_ff, found_in;
   logic             retry_ff, retry_in;
   logic             ret_ff, ret_in;
   logic [DataW-1:0] accum_ff, accum_in;
   logic [DataW-1:0] lo_ff, lo_in;
   logic [PartW-1:0] part_ff, part_in;
   logic [HandleW-1:0] handle_ff, handle_in;
   logic [DataW-1:0] len_ff, len_in;
   rsp_type          pend_ff, pend_in;
   rsp_type          rsp_ff;
   logic             rsp_valid_ff;
   logic             load_rsp;
   rsp_type          rsp_next;

   // Helpers
   entry_type        rd;
   logic             accept, slot_free, idx_lt_cnt;
   logic             fit_take, fit_bad, need_split, free_hit, tail_ok;
   logic [CntW-1:0]  idx_inc, idx_dec, pos_inc, pos_dec;
   logic [DataW-1:0] part_len;
   logic [DataW:0]   seg_end, hi, clip_a, clip_e;
   logic [DataW+2:0] empty4, part1, part3;
   logic [1:0]       rep_level;

   assign rd         = mem_rdata_ff;
   assign accept     = req_valid && req_ready;
   assign slot_free  = !rsp_valid_ff || rsp_ready;
   assign idx_lt_cnt = idx_ff < count_ff;
   assign idx_inc    = idx_ff + CntW'(1);
   assign idx_dec    = idx_ff - CntW'(1);
   assign pos_inc    = pos_ff + CntW'(1);
   assign pos_dec    = pos_ff - CntW'(1);
   assign fit_take   = !rd.used && (rd.size >= len_ff) &&
                       (!found_ff || (rd.size < cur_ff.size));
   assign need_split = cur_ff.size > len_ff;
   assign fit_bad    = !found_ff || (need_split && (count_ff >= CntW'(MaxSegments)));
   assign free_hit   = rd.used && (rd.owner == handle_ff);
   assign tail_ok    = (free_ff != '0) && (pos_ff < CntW'(MaxSegments));

   // Report window clipping
   assign part_len = disk_ff >> PartW;
   assign hi       = {1'b0, lo_ff} + {1'b0, part_len};
   assign seg_end  = {1'b0, rd.start} + {1'b0, rd.size};
   assign clip_a   = (rd.start > lo_ff) ? {1'b0, rd.start} : {1'b0, lo_ff};
   assign clip_e   = (seg_end < hi) ? seg_end : hi;
   assign empty4   = {1'b0, accum_ff, 2'b00};
   assign part1    = {{3{1'b0}}, part_len};
   assign part3    = part1 + (part1 << 1);

   always_comb begin
      if (empty4 <= part1) begin
         rep_level = LVL_FULL;
      end else if (empty4 <= part3) begin
         rep_level = LVL_PARTIAL;
      end else begin
         rep_level = LVL_EMPTY;
      end
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_INIT: state_in = S_IDLE;
         S_IDLE: begin
            if (accept) begin
               unique case (req_data.mode)
                  MODE_ALLOC: begin
                     if (req_data.length == '0 || req_data.length > free_ff) begin
                        state_in = S_RESP;
                     end else begin
                        state_in = S_FIT_RD;
                     end
                  end
                  MODE_FREE:    state_in = S_FREE_RD;
                  MODE_COMPACT: state_in = S_CMP_RD;
                  default:      state_in = S_REP_RD;
               endcase
            end
         end
         S_FIT_RD:  state_in = idx_lt_cnt ? S_FIT_EX : S_FIT_END;
         S_FIT_EX:  state_in = S_FIT_RD;
         S_FIT_END: begin
            priority if (fit_bad) begin
               state_in = retry_ff ? S_RESP : S_CMP_RD;
            end else if (need_split) begin
               state_in = S_SH_RD;
            end else begin
               state_in = S_ALC_WR;
            end
         end
         S_SH_RD:   state_in = (idx_ff > pos_inc) ? S_SH_EX : S_SPL_WR;
         S_SH_EX:   state_in = S_SH_RD;
         S_SPL_WR:  state_in = S_ALC_WR;
         S_ALC_WR:  state_in = S_RESP;
         S_FREE_RD: state_in = idx_lt_cnt ? S_FREE_EX : S_RESP;
         S_FREE_EX: state_in = free_hit ? S_NX_RD : S_FREE_RD;
         S_NX_RD:   state_in = (pos_inc < count_ff) ? S_NX_EX : S_PV_RD;
         S_NX_EX:   state_in = rd.used ? S_PV_RD : S_RM_RD;
         S_PV_RD:   state_in = (pos_ff != '0) ? S_PV_EX : S_RESP;
         S_PV_EX:   state_in = rd.used ? S_RESP : S_RM_RD;
         S_RM_RD: begin
            if (idx_lt_cnt) begin
               state_in = S_RM_EX;
            end else begin
               state_in = ret_ff ? S_RESP : S_PV_RD;
            end
         end
         S_RM_EX:    state_in = S_RM_RD;
         S_CMP_RD:   state_in = idx_lt_cnt ? S_CMP_EX : S_CMP_TAIL;
         S_CMP_EX:   state_in = S_CMP_RD;
         S_CMP_TAIL: state_in = ret_ff ? S_FIT_RD : S_RESP;
         S_REP_RD:   state_in = idx_lt_cnt ? S_REP_EX : S_REP_OUT;
         S_REP_EX:   state_in = S_REP_RD;
         S_REP_OUT: begin
            if (slot_free) begin
               state_in = (part_ff == PartW'(7)) ? S_IDLE : S_REP_RD;
            end
         end
         S_RESP:  state_in = slot_free ? S_IDLE : S_RESP;
         default: state_in = S_INIT;
      endcase
      if (csr_write_en) begin
         state_in = S_INIT;
      end
   end

   // Datapath and RAM control
   always_comb begin
      disk_in   = disk_ff;
      free_in   = free_ff;
      count_in  = count_ff;
      idx_in    = idx_ff;
      pos_in    = pos_ff;
      cur_in    = cur_ff;
      found_in  = found_ff;
      retry_in  = retry_ff;
      ret_in    = ret_ff;
      accum_in  = accum_ff;
      lo_in     = lo_ff;
      part_in   = part_ff;
      handle_in = handle_ff;
      len_in    = len_ff;
      pend_in   = pend_ff;
      mem_we    = 1'b0;
      mem_waddr = pos_ff[SegAw-1:0];
      mem_wdata = cur_ff;
      mem_raddr = idx_ff[SegAw-1:0];
      load_rsp  = 1'b0;
      rsp_next  = pend_ff;

      unique case (state_ff)
         // Rebuild the table as one free segment
         S_INIT: begin
            mem_we    = 1'b1;
            mem_waddr = '0;
            mem_wdata = '{start: '0, size: disk_ff, used: 1'b0, owner: '0};
            count_in  = CntW'(1);
            free_in   = disk_ff;
         end
         // Capture command and preset the walk
         S_IDLE: begin
            if (accept) begin
               handle_in = req_data.handle;
               len_in    = req_data.length;
               idx_in    = '0;
               pos_in    = '0;
               found_in  = 1'b0;
               retry_in  = 1'b0;
               ret_in    = 1'b0;
               accum_in  = '0;
               lo_in     = '0;
               part_in   = '0;
               pend_in   = '{status: STAT_DONE, address: '0, level: '0, last: 1'b1};
               if (req_data.mode == MODE_ALLOC) begin
                  if (req_data.length == '0) begin
                     pend_in.status = STAT_IGNORED;
                  end else if (req_data.length > free_ff) begin
                     pend_in.status = STAT_FULL;
                  end
               end
            end
         end
         // Best-fit search
         S_FIT_EX: begin
            if (fit_take) begin
               found_in = 1'b1;
               pos_in   = idx_ff;
               cur_in   = rd;
            end
            idx_in = idx_inc;
         end
         S_FIT_END: begin
            priority if (fit_bad) begin
               if (retry_ff) begin
                  pend_in.status = STAT_FULL;
               end else begin
                  retry_in = 1'b1;
                  ret_in   = 1'b1;
                  idx_in   = '0;
                  pos_in   = '0;
                  accum_in = '0;
               end
            end else begin
               idx_in = count_ff;
            end
         end
         // Open a hole at pos+1 by shifting the upper entries up
         S_SH_RD: begin
            mem_raddr = idx_dec[SegAw-1:0];
         end
         S_SH_EX: begin
            mem_we    = 1'b1;
            mem_waddr = idx_ff[SegAw-1:0];
            mem_wdata = rd;
            idx_in    = idx_dec;
         end
         S_SPL_WR: begin
            mem_we    = 1'b1;
            mem_waddr = pos_inc[SegAw-1:0];
            mem_wdata = '{start: cur_ff.start + len_ff, size: cur_ff.size - len_ff,
                          used: 1'b0, owner: '0};
            count_in  = count_ff + CntW'(1);
         end
         S_ALC_WR: begin
            mem_we    = 1'b1;
            mem_wdata = '{start: cur_ff.start, size: len_ff, used: 1'b1, owner: handle_ff};
            free_in   = free_ff - len_ff;
            pend_in   = '{status: STAT_PLACED, address: cur_ff.start, level: '0, last: 1'b1};
         end
         // Free: find the owner's lowest segment
         S_FREE_RD: begin
            if (!idx_lt_cnt) begin
               pend_in.status = STAT_IGNORED;
            end
         end
         S_FREE_EX: begin
            if (free_hit) begin
               pos_in  = idx_ff;
               cur_in  = '{start: rd.start, size: rd.size, used: 1'b0, owner: '0};
               free_in = free_ff + rd.size;
            end else begin
               idx_in = idx_inc;
            end
         end
         S_NX_RD: begin
            mem_raddr = pos_inc[SegAw-1:0];
         end
         S_NX_EX: begin
            if (!rd.used) begin
               cur_in.size = cur_ff.size + rd.size;
               idx_in      = pos_ff + CntW'(2);
               ret_in      = 1'b0;
            end
         end
         S_PV_RD: begin
            mem_raddr = pos_dec[SegAw-1:0];
            if (pos_ff == '0) begin
               mem_we = 1'b1;
            end
         end
         S_PV_EX: begin
            mem_we = 1'b1;
            if (!rd.used) begin
               mem_waddr = pos_dec[SegAw-1:0];
               mem_wdata = '{start: rd.start, size: rd.size + cur_ff.size,
                             used: 1'b0, owner: '0};
               idx_in    = pos_inc;
               ret_in    = 1'b1;
            end
         end
         // Close the gap left by a merged entry
         S_RM_RD: begin
            if (!idx_lt_cnt) begin
               count_in = count_ff - CntW'(1);
            end
         end
         S_RM_EX: begin
            mem_we    = 1'b1;
            mem_waddr = idx_dec[SegAw-1:0];
            mem_wdata = rd;
            idx_in    = idx_inc;
         end
         // Compaction: pack used entries down, then one free tail when space and a slot remain
         S_CMP_EX: begin
            if (rd.used) begin
               mem_we    = 1'b1;
               mem_wdata = '{start: accum_ff, size: rd.size, used: 1'b1, owner: rd.owner};
               accum_in  = accum_ff + rd.size;
               pos_in    = pos_inc;
            end
            idx_in = idx_inc;
         end
         S_CMP_TAIL: begin
            if (tail_ok) begin
               mem_we    = 1'b1;
               mem_wdata = '{start: accum_ff, size: free_ff, used: 1'b0, owner: '0};
               count_in  = pos_inc;
            end else begin
               count_in  = pos_ff;
            end
            ret_in   = 1'b0;
            idx_in   = '0;
            found_in = 1'b0;
         end
         // Report: accumulate free space inside the current eighth
         S_REP_EX: begin
            if (!rd.used && (clip_e > clip_a)) begin
               accum_in = accum_ff + DataW'(clip_e - clip_a);
            end
            idx_in = idx_inc;
         end
         S_REP_OUT: begin
            if (slot_free) begin
               load_rsp = 1'b1;
               rsp_next = '{status: STAT_DONE, address: lo_ff, level: rep_level,
                            last: (part_ff == PartW'(7))};
               part_in  = part_ff + PartW'(1);
               lo_in    = lo_ff + part_len;
               idx_in   = '0;
               accum_in = '0;
            end
         end
         S_RESP: begin
            load_rsp = slot_free;
         end
         default: begin
         end
      endcase

      // Size write: clamp to the minimum disk
      if (csr_write_en) begin
         disk_in = (csr_write_data < DiskMin) ? DiskMin : csr_write_data;
      end
   end

   // RAM: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         mem[mem_waddr] <= mem_wdata;
      end
      mem_rdata_ff <= mem[mem_raddr];
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_INIT;
         disk_ff      <= DiskReset;
         count_ff     <= CntW'(1);
         free_ff      <= DiskReset;
         rsp_valid_ff <= 1'b0;
         found_ff     <= 1'b0;
         retry_ff     <= 1'b0;
         ret_ff       <= 1'b0;
         idx_ff       <= '0;
         pos_ff       <= '0;
         part_ff      <= '0;
      end else begin
         state_ff <= state_in;
         disk_ff  <= disk_in;
         count_ff <= count_in;
         free_ff  <= free_in;
         found_ff <= found_in;
         retry_ff <= retry_in;
         ret_ff   <= ret_in;
         idx_ff   <= idx_in;
         pos_ff   <= pos_in;
         part_ff  <= part_in;
         if (load_rsp) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      cur_ff    <= cur_in;
      accum_ff  <= accum_in;
      lo_ff     <= lo_in;
      handle_ff <= handle_in;
      len_ff    <= len_in;
      pend_ff   <= pend_in;
      if (load_rsp) begin
         rsp_ff <= rsp_next;
      end
   end

endmodule

// ===== rtl/bfsa_checker.sv =====
// Port-level checks for the best-fit segment allocator, bound to the top level.
// Depends on bfsa_pkg and assert_macros.svh.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module bfsa_checker
   import bfsa_pkg::*;
(
   input logic             clock,
   input logic             reset,
   input logic             req_valid,
   input logic             req_ready,
   input req_type          req_data,
   input logic             rsp_valid,
   input logic             rsp_ready,
   input rsp_type          rsp_data,
   input logic             csr_write_en,
   input logic [DataW-1:0] csr_write_data
);

   // Held result stays offered
   `BFSA_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid, "rsp dropped")
   // Held result keeps its payload
   `BFSA_ASSERT_NXT(a_rsp_stable, clock, reset, rsp_valid && !rsp_ready, $stable(rsp_data), "rsp changed")
   // Level stays zero on results other than done
   `BFSA_ASSERT_IMP(a_level, clock, reset, rsp_valid && rsp_data.status != STAT_DONE, rsp_data.level == 2'd0, "level set")
   // No address on rejected commands
   `BFSA_ASSERT_IMP(a_addr, clock, reset, rsp_valid && (rsp_data.status == STAT_FULL || rsp_data.status == STAT_IGNORED), rsp_data.address == '0, "address set")
   // Table rebuild blocks the next transfer
   `BFSA_ASSERT_NXT(a_csr_busy, clock, reset, csr_write_en, !req_ready, "ready during rebuild")

endmodule

bind best_fit_segment_allocator bfsa_checker u_bfsa_checker (.*);

// ===== tb/best_fit_segment_allocator_checker.sv =====
// Checker for the best-fit segment allocator: keeps its own segment table,
// predicts every result and compares the result channel against it.
// Depends on bfsa_pkg.
`timescale 1ns / 1ps

module best_fit_segment_allocator_checker
   import bfsa_pkg::*;
(
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_ready,
   input  req_type          req_data,
   input  logic             rsp_valid,
   input  logic             rsp_ready,
   input  rsp_type          rsp_data,
   input  logic             csr_write_en,
   input  logic [DataW-1:0] csr_write_data,
   output int               fail_count,
   output int               pending,
   output int               checked
);

   localparam int Parts = 8;

   // Shadow copy of the segment table
   logic [DataW-1:0]   tbl_start [MaxSegments];
   logic [DataW-1:0]   tbl_size  [MaxSegments];
   bit                 tbl_used  [MaxSegments];
   logic [HandleW-1:0] tbl_owner [MaxSegments];
   int                 tbl_count;
   logic [DataW-1:0]   free_kb;
   logic [DataW-1:0]   disk_kb;

   rsp_type expected_rsps[$];

   function automatic void clear_table();
      for (int i = 0; i < MaxSegments; i++) begin
         tbl_start[i] = '0;
         tbl_size[i]  = '0;
         tbl_used[i]  = 0;
         tbl_owner[i] = '0;
      end
      tbl_count   = 1;
      tbl_size[0] = disk_kb;
      free_kb     = disk_kb;
   endfunction

   function automatic void move_entry(int dst, int src);
      tbl_start[dst] = tbl_start[src];
      tbl_size[dst]  = tbl_size[src];
      tbl_used[dst]  = tbl_used[src];
      tbl_owner[dst] = tbl_owner[src];
   endfunction

   function automatic void drop_entry(int k);
      for (int j = k + 1; j < tbl_count; j++) move_entry(j - 1, j);
      tbl_count--;
   endfunction

   function automatic void pack_table();
      int n;
      logic [DataW-1:0] addr;
      n    = 0;
      addr = '0;
      for (int i = 0; i < tbl_count; i++) begin
         if (tbl_used[i]) begin
            move_entry(n, i);
            tbl_start[n] = addr;
            addr += tbl_size[n];
            n++;
         end
      end
      // one free tail behind the packed segments
      if (free_kb > 0 && n < MaxSegments) begin
         tbl_start[n] = addr;
         tbl_size[n]  = free_kb;
         tbl_used[n]  = 0;
         tbl_owner[n] = '0;
         n++;
      end
      tbl_count = n;
   endfunction

   function automatic int best_fit(logic [DataW-1:0] len);
      int best;
      best = -1;
      for (int i = 0; i < tbl_count; i++)
         if (!tbl_used[i] && tbl_size[i] >= len &&
             (best < 0 || tbl_size[i] < tbl_size[best]))
            best = i;
      return best;
   endfunction

   function automatic void push_rsp(status_type st, logic [DataW-1:0] addr,
                                    level_type lvl, bit fin);
      rsp_type r;
      r.status  = st;
      r.address = addr;
      r.level   = lvl;
      r.last    = fin;
      expected_rsps.push_back(r);
   endfunction

   function automatic void predict_alloc(logic [HandleW-1:0] h, logic [DataW-1:0] len);
      int b;
      if (len == 0) begin
         push_rsp(STAT_IGNORED, '0, LVL_FULL, 1);
         return;
      end
      if (len > free_kb) begin
         push_rsp(STAT_FULL, '0, LVL_FULL, 1);
         return;
      end
      b = best_fit(len);
      // compact and retry when nothing fits or the table cannot split
      if (b < 0 || (tbl_size[b] > len && tbl_count >= MaxSegments)) begin
         pack_table();
         b = best_fit(len);
      end
      if (b < 0 || (tbl_size[b] > len && tbl_count >= MaxSegments)) begin
         push_rsp(STAT_FULL, '0, LVL_FULL, 1);
         return;
      end
      if (tbl_size[b] > len) begin
         for (int j = tbl_count; j > b + 1; j--) move_entry(j, j - 1);
         tbl_start[b+1] = tbl_start[b] + len;
         tbl_size[b+1]  = tbl_size[b] - len;
         tbl_used[b+1]  = 0;
         tbl_owner[b+1] = '0;
         tbl_count++;
      end
      tbl_size[b]  = len;
      tbl_used[b]  = 1;
      tbl_owner[b] = h;
      free_kb -= len;
      push_rsp(STAT_PLACED, tbl_start[b], LVL_FULL, 1);
   endfunction

   function automatic void predict_free(logic [HandleW-1:0] h);
      int i;
      i = 0;
      while (i < tbl_count && !(tbl_used[i] && tbl_owner[i] == h)) i++;
      if (i >= tbl_count) begin
         push_rsp(STAT_IGNORED, '0, LVL_FULL, 1);
         return;
      end
      tbl_used[i]  = 0;
      tbl_owner[i] = '0;
      free_kb += tbl_size[i];
      // merge with free neighbors, upper first
      if (i + 1 < tbl_count && !tbl_used[i+1]) begin
         tbl_size[i] += tbl_size[i+1];
         drop_entry(i + 1);
      end
      if (i > 0 && !tbl_used[i-1]) begin
         tbl_size[i-1] += tbl_size[i];
         drop_entry(i);
      end
      push_rsp(STAT_DONE, '0, LVL_FULL, 1);
   endfunction

   function automatic void predict_report();
      longint part, lo, hi, empty, a, e;
      level_type lvl;
      part = longint'(disk_kb) / Parts;
      for (int k = 0; k < Parts; k++) begin
         lo    = k * part;
         hi    = lo + part;
         empty = 0;
         for (int i = 0; i < tbl_count; i++) begin
            if (!tbl_used[i]) begin
               a = tbl_start[i];
               e = a + tbl_size[i];
               if (a < lo) a = lo;
               if (e > hi) e = hi;
               if (e > a) empty += e - a;
            end
         end
         if (4 * empty <= part)          lvl = LVL_FULL;
         else if (4 * empty <= 3 * part) lvl = LVL_PARTIAL;
         else                            lvl = LVL_EMPTY;
         push_rsp(STAT_DONE, DataW'(lo), lvl, k == Parts - 1);
      end
   endfunction

   function automatic void compare_rsp(rsp_type got);
      rsp_type want;
      checked++;
      if (expected_rsps.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: unexpected result %p", $realtime, got);
         return;
      end
      want = expected_rsps.pop_front();
      if (got.status !== want.status || got.address !== want.address ||
          got.level !== want.level || got.last !== want.last) begin
         fail_count++;
         if (fail_count <= 10)
            $display("%0t: result mismatch, expected %p, got %p", $realtime, want, got);
      end
   endfunction

   initial begin
      fail_count = 0;
      checked    = 0;
      disk_kb    = DiskReset;
      clear_table();
   end

   assign pending = expected_rsps.size();

   // Track resets and size writes, check the result transfer, then predict the request
   always @(posedge clock) begin
      if (reset) begin
         disk_kb = DiskReset;
         clear_table();
         expected_rsps.delete();
      end else if (csr_write_en) begin
         disk_kb = (csr_write_data < DiskMin) ? DiskMin : csr_write_data;
         clear_table();
      end else begin
         if (rsp_valid && rsp_ready) compare_rsp(rsp_data);
         if (req_valid && req_ready) begin
            case (mode_type'(req_data.mode))
               MODE_ALLOC:   predict_alloc(req_data.handle, req_data.length);
               MODE_FREE:    predict_free(req_data.handle);
               MODE_COMPACT: begin
                  pack_table();
                  push_rsp(STAT_DONE, '0, LVL_FULL, 1);
               end
               default:      predict_report();
            endcase
         end
      end
   end

endmodule

// ===== tb/best_fit_segment_allocator_test.sv =====
// Testbench top for the best-fit segment allocator: clock, reset, stimulus,
// receiver stalls and verdict. Depends on bfsa_pkg, the block and its checker.
`timescale 1ns / 1ps

module best_fit_segment_allocator_test;
   import bfsa_pkg::*;

   localparam int CycleLimit = 3000000;

   logic             clock;
   logic             reset;
   logic             req_valid;
   logic             req_ready;
   req_type          req_data;
   logic             rsp_valid;
   logic             rsp_ready;
   rsp_type          rsp_data;
   logic             csr_write_en;
   logic [DataW-1:0] csr_write_data;

   int     fail_count;
   int     pending;
   int     checked;
   int     cycles;
   int     sent;
   int     size_writes;
   bit     hold_req;
   bit     use_gaps;
   longint disk_kb;

   best_fit_segment_allocator u_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data)
   );

   best_fit_segment_allocator_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .csr_write_en   (csr_write_en),
      .csr_write_data (csr_write_data),
      .fail_count     (fail_count),
      .pending        (pending),
      .checked        (checked)
   );

   initial begin
      clock = 0;
      forever #2 clock = ~clock;
   end

   // Watchdog
   initial begin
      cycles = 0;
      while (cycles < CycleLimit) begin
         @(posedge clock);
         cycles++;
      end
      $display("best_fit_segment_allocator_test: errors");
      $finish;
   end

   // Receiver: stretches of full speed, random stalls, and one long hold-off on request
   initial begin : receiver
      int pick, span;
      rsp_ready = 0;
      forever begin
         if (hold_req) begin
            rsp_ready <= 0;
            repeat (1500) @(posedge clock);
            hold_req = 0;
         end else begin
            pick = $urandom_range(0, 99);
            span = $urandom_range(1, 40);
            repeat (span) begin
               if (pick < 30)      rsp_ready <= 1;
               else if (pick < 95) rsp_ready <= ($urandom_range(0, 99) < 65);
               else                rsp_ready <= 0;
               @(posedge clock);
            end
         end
      end
   end

   function automatic int pick_gap();
      int p;
      p = $urandom_range(0, 99);
      if (!use_gaps || p < 40) return 0;
      if (p < 85) return $urandom_range(1, 3);
      if (p < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [DataW-1:0] pick_length();
      int p;
      longint cap;
      p   = $urandom_range(0, 99);
      cap = disk_kb / 16;
      if (cap < 1) cap = 1;
      if (p < 4)  return '0;
      if (p < 12) return DataW'($urandom());
      if (p < 22) return DataW'($urandom_range(1, int'(disk_kb)));
      return DataW'($urandom_range(1, int'(cap)));
   endfunction

   // Offer one command and hold it until the transfer
   task automatic send_cmd(mode_type m, logic [HandleW-1:0] h, logic [DataW-1:0] len);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(posedge clock);
      end
      req_valid       <= 1;
      req_data.mode   <= m;
      req_data.handle <= h;
      req_data.length <= len;
      do @(negedge clock); while (!req_ready);
      @(posedge clock);
      sent++;
   endtask

   // Drop valid and wait until every expected result has come back
   task automatic drain();
      req_valid <= 0;
      do @(negedge clock); while (pending != 0);
      @(posedge clock);
   endtask

   task automatic write_size(logic [DataW-1:0] kb);
      drain();
      repeat (20) @(posedge clock);
      csr_write_en   <= 1;
      csr_write_data <= kb;
      @(posedge clock);
      csr_write_en <= 0;
      disk_kb = (kb < DiskMin) ? DiskMin : kb;
      size_writes++;
   endtask

   task automatic random_cmds(int n);
      int p;
      logic [HandleW-1:0] h;
      repeat (n) begin
         p = $urandom_range(0, 99);
         h = ($urandom_range(0, 99) < 85) ? HandleW'($urandom_range(0, 15))
                                          : HandleW'($urandom_range(0, 255));
         if (p < 45)      send_cmd(MODE_ALLOC, h, pick_length());
         else if (p < 80) send_cmd(MODE_FREE, h, DataW'($urandom()));
         else if (p < 88) send_cmd(MODE_COMPACT, h, DataW'($urandom()));
         else             send_cmd(MODE_REPORT, h, DataW'($urandom()));
      end
   endtask

   initial begin
      reset          = 1;
      req_valid      = 0;
      req_data       = '0;
      csr_write_en   = 0;
      csr_write_data = '0;
      hold_req       = 0;
      use_gaps       = 1;
      sent           = 0;
      size_writes    = 0;
      disk_kb        = DiskReset;
      repeat (3) @(posedge clock);
      reset <= 0;

      // Directed: default disk, field extremes, every command and the corner cases
      send_cmd(MODE_REPORT, 8'd0, '0);
      send_cmd(MODE_ALLOC, 8'd0, 31'd1);
      send_cmd(MODE_ALLOC, 8'd255, '0);
      send_cmd(MODE_ALLOC, 8'd7, 31'h7FFF_FFFF);
      send_cmd(MODE_ALLOC, 8'd255, 31'd4096);
      send_cmd(MODE_ALLOC, 8'd0, 31'd2048);
      send_cmd(MODE_FREE, 8'd99, '0);
      send_cmd(MODE_FREE, 8'd0, 31'h7FFF_FFFF);
      send_cmd(MODE_REPORT, 8'd255, 31'h7FFF_FFFF);
      send_cmd(MODE_COMPACT, 8'd0, '0);
      send_cmd(MODE_ALLOC, 8'd3, 31'd1044479);
      send_cmd(MODE_REPORT, 8'd0, '0);
      send_cmd(MODE_FREE, 8'd0, '0);
      send_cmd(MODE_FREE, 8'd255, '0);
      send_cmd(MODE_ALLOC, 8'd9, 31'd5000);
      send_cmd(MODE_REPORT, 8'd0, '0);

      // Smallest disk: a size below the minimum is raised to it
      write_size('0);
      send_cmd(MODE_ALLOC, 8'd1, 31'd8);
      send_cmd(MODE_ALLOC, 8'd2, 31'd1);
      send_cmd(MODE_REPORT, 8'd0, '0);
      send_cmd(MODE_FREE, 8'd1, '0);
      send_cmd(MODE_REPORT, 8'd0, '0);

      // Random phases over several disk sizes, extremes included
      write_size(31'd1024);
      random_cmds(40);
      write_size(31'd100);
      use_gaps = 0;
      hold_req = 1;
      random_cmds(35);
      use_gaps = 1;
      drain();
      random_cmds(10);
      write_size(31'd1073741824);
      random_cmds(40);
      write_size(31'h7FFF_FFFF);
      random_cmds(40);
      write_size(31'd8);
      random_cmds(45);

      // Wind down
      drain();
      repeat (100) @(posedge clock);
      $display("Sent %0d commands over %0d disk sizes, %0d results checked.",
               sent, size_writes + 1, checked);
      if (fail_count == 0)
         $display("best_fit_segment_allocator_test: clean");
      else
         $display("best_fit_segment_allocator_test: errors");
      $finish;
   end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/bfsa_pkg.sv
rtl/best_fit_segment_allocator.sv
rtl/bfsa_checker.sv
tb/best_fit_segment_allocator_checker.sv
tb/best_fit_segment_allocator_test.sv
